/* rtl/ssr_pkg.sv */
// Shared types and constants for the stream substring replace block.
// No dependencies; the cell, window and core files in rtl/ refer to this package by scoped names.
package ssr_pkg;

  localparam int CHAR_W              = 8;
  localparam int CFG_DATA_W          = 64;
  localparam int CFG_INDEX_W         = 3;
  localparam int PATTERN_MAX_DEFAULT = 8;
  localparam int REPLACE_MAX         = 16;
  localparam int PLEN_W              = 4;
  localparam int RLEN_W              = 5;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LOW    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_HIGH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd4;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              has_char;
    logic              run_last;
    logic              string_done;
  } out_item_t;

  // Control handed from the sequencer to every window cell
  typedef struct packed {
    logic              shift;
    logic              append;
    logic [CHAR_W-1:0] new_char;
  } win_ctl_t;

endpackage

/* rtl/ssr_stream_if.sv */
// Valid/ready stream channel carrying one payload item per beat.
// Depends on nothing; the payload type is chosen per instance.
interface ssr_stream_if #(parameter type item_t = logic) ();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/ssr_cell.sv */
// One window cell: holds one byte, shifts toward the head, compares against its pattern byte.
// Depends on ssr_pkg.
module ssr_cell (
  input  logic                             clk,
  input  ssr_pkg::win_ctl_t                ctl,
  input  logic                             at_pos,
  input  logic                             before_pos,
  input  logic [ssr_pkg::CHAR_W-1:0]       neighbor,
  input  logic [ssr_pkg::CHAR_W-1:0]       pattern_char,
  output logic [ssr_pkg::CHAR_W-1:0]       held,
  output logic                             match
);

  // Compare the byte this cell would hold once the incoming byte is appended
  assign match = (pattern_char == (at_pos ? ctl.new_char : held));

  // Shift from the neighbor, or take the new byte at the append slot
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      held <= (ctl.append && before_pos) ? ctl.new_char : neighbor;
    end else if (ctl.append && at_pos) begin
      held <= ctl.new_char;
    end
  end

endmodule

/* rtl/ssr_window.sv */
// Row of match window cells, oldest byte in cell 0, plus the pattern hit reduction.
// Depends on ssr_pkg and ssr_cell.
module ssr_window #(
  parameter int CELLS = ssr_pkg::PATTERN_MAX_DEFAULT,
  parameter int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic                                clk,
  input  ssr_pkg::win_ctl_t                   ctl,
  input  logic [IDX_W-1:0]                    pos,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]      pattern_bytes,
  output logic [ssr_pkg::CHAR_W-1:0]          head,
  output logic                                hit
);

  logic [ssr_pkg::CHAR_W-1:0] held [CELLS];
  logic [CELLS-1:0]           match;
  logic [CELLS-1:0]           upto_pos;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic [ssr_pkg::CHAR_W-1:0] neighbor;

    if (i == CELLS - 1) begin : g_tail
      assign neighbor = '0;
    end else begin : g_body
      assign neighbor = held[i+1];
    end

    assign upto_pos[i] = ({1'b0, pos} >= (IDX_W+1)'(i));

    ssr_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .at_pos       (pos == IDX_W'(i)),
      .before_pos   ({1'b0, pos} == (IDX_W+1)'(i + 1)),
      .neighbor     (neighbor),
      .pattern_char (pattern_bytes[ssr_pkg::CHAR_W*i +: ssr_pkg::CHAR_W]),
      .held         (held[i]),
      .match        (match[i])
    );
  end

  assign head = held[0];

  // Every cell up to the append slot must equal its pattern byte
  assign hit = &(match | ~upto_pos);

endmodule

/* rtl/stream_substring_replace_core.sv */
// Streaming substring replace: one byte accepted per cycle while the output is not stalled and no
// replacement or flush is in progress; result beats come from a registered output.
// A match with more than one replacement byte holds the input until the rest are sent, and the last
// byte of a string holds it until every byte left in the window has been sent.
// Reset (synchronous, active high) empties the window and loads the register defaults.
module stream_substring_replace_core #(
  parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  ssr_stream_if.sink                             din,
  ssr_stream_if.source                           dout,
  input  logic                                   cfg_write,
  input  logic [ssr_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int FILL_W = $clog2(PATTERN_MAX + 1);

  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_REPL   = 2'd1;
  localparam logic [1:0] ST_FLUSH  = 2'd2;

  // Configuration registers
  logic [ssr_pkg::CFG_DATA_W-1:0] pattern_bytes;
  logic [ssr_pkg::PLEN_W-1:0]     pattern_length;
  logic [ssr_pkg::CFG_DATA_W-1:0] replacement_low;
  logic [ssr_pkg::CFG_DATA_W-1:0] replacement_high;
  logic [ssr_pkg::RLEN_W-1:0]     replacement_length;

  // Sequencer state
  logic [1:0]        state, state_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [3:0]        idx, idx_next;
  logic              last, last_next;

  // Output register
  logic               out_valid;
  ssr_pkg::out_item_t out_item;
  ssr_pkg::out_item_t beat;
  logic               beat_load;

  logic                        advance;
  logic                        take;
  logic [FILL_W-1:0]           plen;
  logic [ssr_pkg::RLEN_W-1:0]  rlen;
  logic [IDX_W-1:0]            pos;
  logic                        full;
  logic [2*ssr_pkg::CFG_DATA_W-1:0] rep_word;
  logic [ssr_pkg::CHAR_W-1:0]  win_head;
  logic                        win_hit;
  ssr_pkg::win_ctl_t           ctl;
  ssr_pkg::in_item_t           item;

  // Clamp the configured lengths
  always_comb begin
    if (pattern_length == '0) begin
      plen = FILL_W'(1);
    end else if (pattern_length > ssr_pkg::PLEN_W'(PATTERN_MAX)) begin
      plen = FILL_W'(PATTERN_MAX);
    end else begin
      plen = FILL_W'(pattern_length);
    end
  end

  assign rlen = (replacement_length > ssr_pkg::RLEN_W'(ssr_pkg::REPLACE_MAX)) ?
                ssr_pkg::RLEN_W'(ssr_pkg::REPLACE_MAX) : replacement_length;

  assign rep_word = {replacement_high, replacement_low};
  assign item     = din.payload;

  // Append slot and full-window check
  assign pos  = (fill >= plen) ? '0 : IDX_W'(fill);
  assign full = ((FILL_W'(pos) + FILL_W'(1)) == plen);

  assign advance   = !out_valid || dout.ready;
  assign din.ready = (state == ST_ACCEPT) && advance;
  assign take      = din.valid && din.ready;

  ssr_window #(
    .CELLS (PATTERN_MAX),
    .IDX_W (IDX_W)
  ) u_window (
    .clk           (clk),
    .ctl           (ctl),
    .pos           (pos),
    .pattern_bytes (pattern_bytes),
    .head          (win_head),
    .hit           (win_hit)
  );

  // Sequence the result beats of each byte
  always_comb begin
    state_next   = state;
    fill_next    = fill;
    idx_next     = idx;
    last_next    = last;
    ctl.shift    = 1'b0;
    ctl.append   = 1'b0;
    ctl.new_char = item.in_char;
    beat_load    = 1'b0;
    beat         = '0;

    unique case (state)
      ST_ACCEPT: begin
        if (take) begin
          if (full && win_hit) begin
            // Replace the matched window
            fill_next = '0;
            if (rlen != '0) begin
              beat_load        = 1'b1;
              beat.out_char    = rep_word[ssr_pkg::CHAR_W-1:0];
              beat.has_char    = 1'b1;
              beat.run_last    = (rlen == ssr_pkg::RLEN_W'(1));
              beat.string_done = (rlen == ssr_pkg::RLEN_W'(1)) && item.end_of_input;
              if (rlen != ssr_pkg::RLEN_W'(1)) begin
                state_next = ST_REPL;
                idx_next   = 4'd1;
                last_next  = item.end_of_input;
              end
            end else if (item.end_of_input) begin
              beat_load        = 1'b1;
              beat.run_last    = 1'b1;
              beat.string_done = 1'b1;
            end
          end else if (full) begin
            // Emit the oldest byte and slide the window
            ctl.shift     = 1'b1;
            ctl.append    = 1'b1;
            beat_load     = 1'b1;
            beat.out_char = (pos == '0) ? item.in_char : win_head;
            beat.has_char = 1'b1;
            fill_next     = plen - FILL_W'(1);
            if (item.end_of_input && (plen != FILL_W'(1))) begin
              state_next = ST_FLUSH;
            end else begin
              beat.run_last    = 1'b1;
              beat.string_done = item.end_of_input;
            end
          end else begin
            // Grow the window
            ctl.append = 1'b1;
            fill_next  = FILL_W'(pos) + FILL_W'(1);
            if (item.end_of_input) begin
              state_next = ST_FLUSH;
            end
          end
        end
      end

      ST_REPL: begin
        if (advance) begin
          beat_load     = 1'b1;
          beat.out_char = rep_word[ssr_pkg::CHAR_W*idx +: ssr_pkg::CHAR_W];
          beat.has_char = 1'b1;
          if ((ssr_pkg::RLEN_W'(idx) + ssr_pkg::RLEN_W'(1)) == rlen) begin
            beat.run_last    = 1'b1;
            beat.string_done = last;
            state_next       = ST_ACCEPT;
          end else begin
            idx_next = idx + 4'd1;
          end
        end
      end

      ST_FLUSH: begin
        // Drain the window one byte per beat from the head
        if (advance) begin
          ctl.shift     = 1'b1;
          beat_load     = 1'b1;
          beat.out_char = win_head;
          beat.has_char = 1'b1;
          fill_next     = fill - FILL_W'(1);
          if (fill == FILL_W'(1)) begin
            beat.run_last    = 1'b1;
            beat.string_done = 1'b1;
            state_next       = ST_ACCEPT;
          end
        end
      end

      default: begin
        state_next = ST_ACCEPT;
      end
    endcase

    // A new pattern length discards the window
    if (cfg_write && (cfg_index == ssr_pkg::REG_PATTERN_LENGTH)) begin
      fill_next = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCEPT;
      fill      <= '0;
      idx       <= '0;
      last      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      idx   <= idx_next;
      last  <= last_next;
      if (advance) begin
        out_valid <= beat_load;
      end
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= beat;
    end
  end

  assign dout.valid   = out_valid;
  assign dout.payload = out_item;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= ssr_pkg::PLEN_W'(1);
      replacement_low    <= '0;
      replacement_high   <= '0;
      replacement_length <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ssr_pkg::REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        ssr_pkg::REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[ssr_pkg::PLEN_W-1:0];
        ssr_pkg::REG_REPLACEMENT_LOW:    replacement_low    <= cfg_data;
        ssr_pkg::REG_REPLACEMENT_HIGH:   replacement_high   <= cfg_data;
        ssr_pkg::REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[ssr_pkg::RLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* tb/sv/stream_substring_replace_core_tb.sv */
// Self-checking bench for stream_substring_replace_core: predicts the replaced byte stream.
// Depends on ssr_pkg, ssr_stream_if and the core; drives both channels and the register port.
module stream_substring_replace_core_tb;

  localparam int CLK_PERIOD   = 12;
  localparam int RANDOM_BYTES = 470;
  localparam int TIMEOUT_CYC  = 400000;
  localparam int SETTLE_CYC   = 4;
  localparam int MAX_REPORTS  = 10;
  localparam int WIN_IDX_W    = $clog2(ssr_pkg::PATTERN_MAX_DEFAULT);
  // First register index past the end of the register list
  localparam logic [ssr_pkg::CFG_INDEX_W-1:0] REG_BEYOND_LIST =
    ssr_pkg::REG_REPLACEMENT_LENGTH + 1'b1;

  // Tracks pattern, replacement and match window; holds the beats still owed by the block
  class replace_scoreboard;
    logic [ssr_pkg::CFG_DATA_W-1:0] pat_bytes;
    logic [ssr_pkg::PLEN_W-1:0]     pat_len;
    logic [ssr_pkg::CFG_DATA_W-1:0] rep_lo;
    logic [ssr_pkg::CFG_DATA_W-1:0] rep_hi;
    logic [ssr_pkg::RLEN_W-1:0]     rep_len;
    logic [ssr_pkg::CHAR_W-1:0]     window [ssr_pkg::PATTERN_MAX_DEFAULT];
    int unsigned                    fill;
    ssr_pkg::out_item_t             expected_beats [$];
    int                             mismatches;

    function new();
      pat_bytes  = '0;
      pat_len    = ssr_pkg::PLEN_W'(1);
      rep_lo     = '0;
      rep_hi     = '0;
      rep_len    = '0;
      fill       = 0;
      mismatches = 0;
      foreach (window[k]) window[k] = '0;
    endfunction

    function int unsigned pattern_span();
      int unsigned n;
      n = pat_len;
      if (n < 1) n = 1;
      if (n > ssr_pkg::PATTERN_MAX_DEFAULT) n = ssr_pkg::PATTERN_MAX_DEFAULT;
      return n;
    endfunction

    // Mirror a register write; a new pattern length drops the window
    function void load_reg(logic [ssr_pkg::CFG_INDEX_W-1:0] idx,
                           logic [ssr_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        ssr_pkg::REG_PATTERN_BYTES:      pat_bytes = data;
        ssr_pkg::REG_PATTERN_LENGTH: begin
          pat_len = data[ssr_pkg::PLEN_W-1:0];
          fill    = 0;
        end
        ssr_pkg::REG_REPLACEMENT_LOW:    rep_lo = data;
        ssr_pkg::REG_REPLACEMENT_HIGH:   rep_hi = data;
        ssr_pkg::REG_REPLACEMENT_LENGTH: rep_len = data[ssr_pkg::RLEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_beat(logic [ssr_pkg::CHAR_W-1:0] ch, logic has);
      ssr_pkg::out_item_t b;
      b.out_char    = ch;
      b.has_char    = has;
      b.run_last    = 1'b0;
      b.string_done = 1'b0;
      expected_beats.push_back(b);
    endfunction

    // Predict the beats caused by one accepted input byte
    function void accept_byte(ssr_pkg::in_item_t item);
      int unsigned        plen, rlen, start, i;
      logic               hit;
      ssr_pkg::out_item_t tail;
      plen  = pattern_span();
      rlen  = rep_len;
      if (rlen > ssr_pkg::REPLACE_MAX) rlen = ssr_pkg::REPLACE_MAX;
      start = expected_beats.size();
      if (fill >= plen) fill = 0;
      window[WIN_IDX_W'(fill)] = item.in_char;
      fill++;
      // Full window: replace on a hit, else release the oldest byte
      if (fill == plen) begin
        hit = 1'b1;
        for (i = 0; i < plen; i++)
          if (window[WIN_IDX_W'(i)] != pat_bytes[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          for (i = 0; i < rlen; i++)
            push_beat((i < 8) ? rep_lo[8*i +: 8] : rep_hi[8*(i-8) +: 8], 1'b1);
          fill = 0;
        end else begin
          push_beat(window[0], 1'b1);
          for (i = 1; i < plen; i++) window[WIN_IDX_W'(i-1)] = window[WIN_IDX_W'(i)];
          fill--;
        end
      end
      // Last byte of a string: flush the window, always give a closing beat
      if (item.end_of_input) begin
        for (i = 0; i < fill; i++) push_beat(window[WIN_IDX_W'(i)], 1'b1);
        fill = 0;
        if (expected_beats.size() == start) push_beat('0, 1'b0);
      end
      if (expected_beats.size() > start) begin
        tail             = expected_beats.pop_back();
        tail.run_last    = 1'b1;
        tail.string_done = item.end_of_input;
        expected_beats.push_back(tail);
      end
    endfunction

    function void note_mismatch(string what, ssr_pkg::out_item_t want,
                                ssr_pkg::out_item_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%s: expected char=%02h has=%0b last=%0b done=%0b, ",
                 what, want.out_char, want.has_char, want.run_last, want.string_done,
                 "got char=%02h has=%0b last=%0b done=%0b",
                 got.out_char, got.has_char, got.run_last, got.string_done);
    endfunction

    // Compare one output beat with the oldest prediction
    function void check_beat(ssr_pkg::out_item_t got);
      ssr_pkg::out_item_t want;
      if (expected_beats.size() == 0) begin
        note_mismatch("unexpected beat", '0, got);
      end else begin
        want = expected_beats.pop_front();
        if (got.out_char !== want.out_char || got.has_char !== want.has_char ||
            got.run_last !== want.run_last || got.string_done !== want.string_done)
          note_mismatch("beat mismatch", want, got);
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [ssr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data;

  ssr_stream_if #(.item_t(ssr_pkg::in_item_t))  din_if ();
  ssr_stream_if #(.item_t(ssr_pkg::out_item_t)) dout_if ();

  stream_substring_replace_core #(.PATTERN_MAX(ssr_pkg::PATTERN_MAX_DEFAULT)) uut (
    .clk       (clk),
    .rst       (rst),
    .din       (din_if),
    .dout      (dout_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  replace_scoreboard sb = new();

  logic [ssr_pkg::CHAR_W-1:0] text_buf [$];
  int                         bytes_sent = 0;
  int                         in_calm    = 0;
  int                         out_calm   = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYC);
    $display("Regression FAIL");
    $finish;
  end

  // Random wait before a beat, with occasional stretches of back-to-back beats
  task automatic draw_gap(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(10, 40);
      gap  = 0;
    end else begin
      gap = $urandom_range(0, 7);
    end
  endtask

  // Offer one input beat and hold it until accepted
  task automatic send_byte(input ssr_pkg::in_item_t item);
    int gap;
    draw_gap(in_calm, gap);
    if (gap > 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_if.valid   <= 1'b1;
    din_if.payload <= item;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    sb.accept_byte(item);
    bytes_sent++;
  endtask

  task automatic send_text(input bit close);
    ssr_pkg::in_item_t item;
    int                i;
    for (i = 0; i < text_buf.size(); i++) begin
      item.in_char      = text_buf[i];
      item.end_of_input = close && (i == text_buf.size() - 1);
      send_byte(item);
    end
  endtask

  // Stop input, wait for every owed beat, then let the block go quiet
  task automatic settle();
    din_if.valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ssr_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ssr_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.load_reg(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // New pattern, mostly from four letters, new replacement; length and stray writes now and then
  task automatic random_config();
    logic [ssr_pkg::CHAR_W-1:0]     letters [4];
    logic [ssr_pkg::CFG_DATA_W-1:0] pat;
    logic [ssr_pkg::CFG_DATA_W-1:0] word;
    int                             k;
    settle();
    foreach (letters[m]) letters[m] = ssr_pkg::CHAR_W'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) begin
      for (k = 0; k < 8; k++) pat[8*k +: 8] = letters[2'($urandom_range(0, 3))];
    end else begin
      pat = {$urandom, $urandom};
    end
    write_reg(ssr_pkg::REG_PATTERN_BYTES, pat);
    if ($urandom_range(0, 1) != 0) begin
      word = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: word[ssr_pkg::PLEN_W-1:0] = '0;
        1: word[ssr_pkg::PLEN_W-1:0] =
             ssr_pkg::PLEN_W'($urandom_range(ssr_pkg::PATTERN_MAX_DEFAULT + 1, 15));
        default: word[ssr_pkg::PLEN_W-1:0] =
             ssr_pkg::PLEN_W'($urandom_range(1, ssr_pkg::PATTERN_MAX_DEFAULT));
      endcase
      write_reg(ssr_pkg::REG_PATTERN_LENGTH, word);
    end
    write_reg(ssr_pkg::REG_REPLACEMENT_LOW, {$urandom, $urandom});
    write_reg(ssr_pkg::REG_REPLACEMENT_HIGH, {$urandom, $urandom});
    word = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0)
      word[ssr_pkg::RLEN_W-1:0] =
        ssr_pkg::RLEN_W'($urandom_range(ssr_pkg::REPLACE_MAX + 1, 31));
    else
      word[ssr_pkg::RLEN_W-1:0] = ssr_pkg::RLEN_W'($urandom_range(0, ssr_pkg::REPLACE_MAX));
    write_reg(ssr_pkg::REG_REPLACEMENT_LENGTH, word);
    if ($urandom_range(0, 7) == 0)
      write_reg(ssr_pkg::CFG_INDEX_W'($urandom_range(REG_BEYOND_LIST,
                                                     2**ssr_pkg::CFG_INDEX_W - 1)),
                {$urandom, $urandom});
  endtask

  // Mostly whole patterns, with broken prefixes and stray bytes between them
  task automatic build_text();
    int unsigned plen;
    int          pieces, k, j, cut, idx;
    plen = sb.pattern_span();
    text_buf.delete();
    pieces = $urandom_range(1, 6);
    for (k = 0; k < pieces; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          for (j = 0; j < plen; j++) text_buf.push_back(sb.pat_bytes[8*j +: 8]);
        end
        5, 6: begin
          cut = (plen > 1) ? $urandom_range(1, plen - 1) : 1;
          for (j = 0; j < cut; j++) text_buf.push_back(sb.pat_bytes[8*j +: 8]);
        end
        7, 8: begin
          idx = $urandom_range(0, plen - 1);
          text_buf.push_back(sb.pat_bytes[8*idx +: 8]);
        end
        default: text_buf.push_back(ssr_pkg::CHAR_W'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Output side: random stalls, check every accepted beat
  initial begin
    int stall;
    dout_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      draw_gap(out_calm, stall);
      if (stall > 0) begin
        dout_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout_if.ready <= 1'b1;
      @(posedge clk);
      while (!dout_if.valid) @(posedge clk);
      sb.check_beat(dout_if.payload);
    end
  end

  initial begin
    int random_start, strings, s;
    bit text_open;
    rst            <= 1'b1;
    din_if.valid   <= 1'b0;
    din_if.payload <= '0;
    cfg_write      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Byte extremes in the pattern, longest replacement with low word all ones and high word zero
    write_reg(ssr_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0000_00FF);
    write_reg(ssr_pkg::REG_PATTERN_LENGTH, 64'd2);
    write_reg(ssr_pkg::REG_REPLACEMENT_LOW, '1);
    write_reg(ssr_pkg::REG_REPLACEMENT_HIGH, '0);
    write_reg(ssr_pkg::REG_REPLACEMENT_LENGTH,
              ssr_pkg::CFG_DATA_W'(ssr_pkg::REPLACE_MAX));
    text_buf = '{8'h00, 8'hFF, 8'h00, 8'hFF};
    send_text(1'b1);
    text_buf = '{8'hFF};
    send_text(1'b1);

    // Zero pattern length acts as one; empty replacement deletes zero bytes
    settle();
    write_reg(ssr_pkg::REG_PATTERN_BYTES, '0);
    write_reg(ssr_pkg::REG_PATTERN_LENGTH, 64'd0);
    write_reg(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
    text_buf = '{8'h00};
    send_text(1'b1);
    text_buf = '{8'h41, 8'h00, 8'h42};
    send_text(1'b1);

    // Oversized lengths clamp; writes past the register list do nothing
    settle();
    write_reg(ssr_pkg::REG_PATTERN_BYTES, '1);
    write_reg(ssr_pkg::REG_PATTERN_LENGTH, 64'd15);
    write_reg(ssr_pkg::REG_REPLACEMENT_LOW, 64'h0123_4567_89AB_CDEF);
    write_reg(ssr_pkg::REG_REPLACEMENT_HIGH, '1);
    write_reg(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd31);
    write_reg(REG_BEYOND_LIST, '0);
    write_reg('1, '0);
    text_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_text(1'b1);

    // Pattern length rewritten mid-string drops the partial window
    settle();
    write_reg(ssr_pkg::REG_PATTERN_LENGTH, 64'd3);
    text_buf = '{8'h01, 8'h02};
    send_text(1'b0);
    settle();
    write_reg(ssr_pkg::REG_PATTERN_LENGTH, 64'd2);
    text_buf = '{8'h03, 8'h04};
    send_text(1'b1);

    // Random phases; some leave a string open across the register writes
    random_start = bytes_sent;
    text_open    = 1'b0;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      random_config();
      strings = $urandom_range(2, 4);
      for (s = 0; s < strings; s++) begin
        build_text();
        text_open = (s == strings - 1) && ($urandom_range(0, 4) == 0);
        send_text(!text_open);
      end
    end
    if (text_open) begin
      text_buf = '{ssr_pkg::CHAR_W'($urandom_range(0, 255))};
      send_text(1'b1);
    end

    settle();
    if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ssr_pkg.sv
rtl/ssr_stream_if.sv
rtl/ssr_cell.sv
rtl/ssr_window.sv
rtl/stream_substring_replace_core.sv
tb/sv/stream_substring_replace_core_tb.sv
